// ----- src/ptdm_pkg.sv -----
package ptdm_pkg;

   localparam int TASK_ID_W = 4;
   localparam int MS_W      = 27;
   localparam int SEC_W     = 32;
   localparam int NSEC_W    = 30;
   localparam int MISS_W    = 16;
   localparam int QUOT_W    = 18;
   localparam int REM_W     = 10;

   localparam logic [MS_W-1:0]   MS_PER_SEC  = 27'd1000;
   localparam logic [NSEC_W-1:0] NS_PER_MS   = 30'd1000000;
   localparam logic [NSEC_W:0]   NS_PER_SEC  = 31'd1000000000;
   localparam logic [27:0]       RECIP_MS    = 28'd137438954;
   localparam int                RECIP_SHIFT = 37;
   localparam logic [MISS_W-1:0] MISS_MAX    = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_CREATE   = 2'd0,
      OP_ACTIVATE = 2'd1,
      OP_CHECK    = 2'd2,
      OP_ADVANCE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STS_OK      = 2'd0,
      STS_FULL    = 2'd1,
      STS_NO_TASK = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_MUL  = 2'd1,
      S_ADD  = 2'd2,
      S_WB   = 2'd3
   } state_type;

   typedef struct packed {
      op_type                 opcode;
      logic [TASK_ID_W-1:0]   task_id;
      logic [SEC_W-1:0]       now_sec;
      logic [NSEC_W-1:0]      now_nsec;
      logic [MS_W-1:0]        period_ms;
      logic [MS_W-1:0]        deadline_ms;
   } req_type;

   typedef struct packed {
      logic [TASK_ID_W-1:0]   result_task;
      status_type             status;
      logic                   missed;
      logic [MISS_W-1:0]      miss_total;
      logic [SEC_W-1:0]       next_act_sec;
      logic [NSEC_W-1:0]      next_act_nsec;
      logic [SEC_W-1:0]       abs_dl_sec;
      logic [NSEC_W-1:0]      abs_dl_nsec;
   } rsp_type;

   typedef struct packed {
      logic [MS_W-1:0]        period_ms;
      logic [MS_W-1:0]        rel_dl_ms;
      logic [SEC_W-1:0]       act_sec;
      logic [NSEC_W-1:0]      act_nsec;
      logic [SEC_W-1:0]       dl_sec;
      logic [NSEC_W-1:0]      dl_nsec;
      logic [MISS_W-1:0]      miss;
   } entry_type;

endpackage

// ----- src/ptdm_ram.sv -----
module ptdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/ptdm_time_add.sv -----
// Adds a millisecond count to a sec/nsec time. Two register stages, then the
// one-second carry fix in the output cycle. Runs every cycle, no enable.
module ptdm_time_add (
   input  logic                         clock,
   input  logic [ptdm_pkg::SEC_W-1:0]   base_sec,
   input  logic [ptdm_pkg::NSEC_W-1:0]  base_nsec,
   input  logic [ptdm_pkg::MS_W-1:0]    ms,
   output logic [ptdm_pkg::SEC_W-1:0]   sum_sec,
   output logic [ptdm_pkg::NSEC_W-1:0]  sum_nsec
);

   localparam int PROD_W = ptdm_pkg::MS_W + 28;

   logic [PROD_W-1:0]                prod;
   logic [ptdm_pkg::QUOT_W-1:0]      quot_ff;
   logic [ptdm_pkg::MS_W-1:0]        ms_ff;
   logic [ptdm_pkg::SEC_W-1:0]       sec1_ff;
   logic [ptdm_pkg::NSEC_W-1:0]      nsec1_ff;

   logic [ptdm_pkg::MS_W-1:0]        quot_ms;
   logic [ptdm_pkg::REM_W-1:0]       rem;
   logic [ptdm_pkg::NSEC_W-1:0]      nsec_add;
   logic [ptdm_pkg::SEC_W-1:0]       sec2_in;
   logic [ptdm_pkg::NSEC_W:0]        nsec2_in;
   logic [ptdm_pkg::SEC_W-1:0]       sec2_ff;
   logic [ptdm_pkg::NSEC_W:0]        nsec2_ff;
   logic [ptdm_pkg::NSEC_W:0]        nsec_wrap;
   logic                             carry;

   // ms / 1000 by reciprocal; exact for every 27-bit ms
   assign prod = PROD_W'(ms) * PROD_W'(ptdm_pkg::RECIP_MS);

   always_ff @(posedge clock) begin
      quot_ff  <= prod[ptdm_pkg::RECIP_SHIFT +: ptdm_pkg::QUOT_W];
      ms_ff    <= ms;
      sec1_ff  <= base_sec;
      nsec1_ff <= base_nsec;
   end

   always_comb begin
      quot_ms  = ptdm_pkg::MS_W'(quot_ff) * ptdm_pkg::MS_PER_SEC;
      rem      = ptdm_pkg::REM_W'(ms_ff - quot_ms);
      nsec_add = ptdm_pkg::NSEC_W'(rem) * ptdm_pkg::NS_PER_MS;
      sec2_in  = sec1_ff + ptdm_pkg::SEC_W'(quot_ff);
      nsec2_in = {1'b0, nsec1_ff} + {1'b0, nsec_add};
   end

   always_ff @(posedge clock) begin
      sec2_ff  <= sec2_in;
      nsec2_ff <= nsec2_in;
   end

   always_comb begin
      carry     = (nsec2_ff >= ptdm_pkg::NS_PER_SEC);
      nsec_wrap = nsec2_ff - ptdm_pkg::NS_PER_SEC;
      sum_nsec  = carry ? nsec_wrap[ptdm_pkg::NSEC_W-1:0] : nsec2_ff[ptdm_pkg::NSEC_W-1:0];
      sum_sec   = sec2_ff + ptdm_pkg::SEC_W'(carry);
   end

endmodule

// ----- src/periodic_task_deadline_monitor_unit.sv -----
// Each accepted beat steps through read, divide, add and write back; the
// result strobe is registered out of the write-back state (S_WB).
// A new beat is taken only once the last is through: busy is high from
// acceptance through S_WB, set by the single read-modify-write of the table.
// Reset clears the task count and control; table contents are not cleared.
module periodic_task_deadline_monitor_unit #(
   parameter int TASK_SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  ptdm_pkg::req_type   req_data,
   output logic                rsp_strobe,
   output ptdm_pkg::rsp_type   rsp_data
);

   localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
   localparam int ADDR_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
   localparam int CMP_W  = (CNT_W > ptdm_pkg::TASK_ID_W) ? CNT_W : ptdm_pkg::TASK_ID_W;
   localparam int ENT_W  = $bits(ptdm_pkg::entry_type);

   ptdm_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   ptdm_pkg::req_type      req_ff;
   logic [ADDR_W-1:0]      slot_ff;
   logic [ptdm_pkg::TASK_ID_W-1:0] tag_ff;
   ptdm_pkg::status_type   status_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   ptdm_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   accept;
   logic [CMP_W-1:0]       cnt_ext, id_ext;
   logic                   full, id_ok;
   logic [ADDR_W-1:0]      rd_addr;
   ptdm_pkg::status_type   status_new;
   logic [ptdm_pkg::TASK_ID_W-1:0] tag_new;

   ptdm_pkg::entry_type    rd_entry, wr_entry;
   logic [ENT_W-1:0]       rd_raw;
   logic                   wr_en;

   logic [ptdm_pkg::SEC_W-1:0]  act_base_sec, dl_base_sec, act_sum_sec, dl_sum_sec;
   logic [ptdm_pkg::NSEC_W-1:0] act_base_nsec, dl_base_nsec, act_sum_nsec, dl_sum_nsec;
   logic [ptdm_pkg::MS_W-1:0]   dl_ms;
   logic                        later;

   assign busy       = (state_ff != ptdm_pkg::S_IDLE);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // admission check and table address, evaluated on the incoming beat
   always_comb begin
      cnt_ext = CMP_W'(count_ff);
      id_ext  = CMP_W'(req_data.task_id);
      full    = (count_ff == CNT_W'(TASK_SLOTS));
      id_ok   = (id_ext < cnt_ext);
      if (req_data.opcode == ptdm_pkg::OP_CREATE) begin
         rd_addr    = count_ff[ADDR_W-1:0];
         status_new = full ? ptdm_pkg::STS_FULL : ptdm_pkg::STS_OK;
         tag_new    = full ? '0 : cnt_ext[ptdm_pkg::TASK_ID_W-1:0];
      end else begin
         rd_addr    = id_ext[ADDR_W-1:0];
         status_new = id_ok ? ptdm_pkg::STS_OK : ptdm_pkg::STS_NO_TASK;
         tag_new    = req_data.task_id;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff    <= req_data;
         slot_ff   <= rd_addr;
         tag_ff    <= tag_new;
         status_ff <= status_new;
      end
      rsp_ff <= rsp_in;
   end

   ptdm_ram #(
      .WIDTH (ENT_W),
      .DEPTH (TASK_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (wr_entry),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign rd_entry = ptdm_pkg::entry_type'(rd_raw);

   // time unit inputs are sampled in S_MUL, while read data is fresh
   always_comb begin
      if (req_ff.opcode == ptdm_pkg::OP_ACTIVATE) begin
         act_base_sec  = req_ff.now_sec;
         act_base_nsec = req_ff.now_nsec;
         dl_base_sec   = req_ff.now_sec;
         dl_base_nsec  = req_ff.now_nsec;
         dl_ms         = rd_entry.rel_dl_ms;
      end else begin
         act_base_sec  = rd_entry.act_sec;
         act_base_nsec = rd_entry.act_nsec;
         dl_base_sec   = rd_entry.dl_sec;
         dl_base_nsec  = rd_entry.dl_nsec;
         dl_ms         = rd_entry.period_ms;
      end
   end

   ptdm_time_add u_act_add (
      .clock     (clock),
      .base_sec  (act_base_sec),
      .base_nsec (act_base_nsec),
      .ms        (rd_entry.period_ms),
      .sum_sec   (act_sum_sec),
      .sum_nsec  (act_sum_nsec)
   );

   ptdm_time_add u_dl_add (
      .clock     (clock),
      .base_sec  (dl_base_sec),
      .base_nsec (dl_base_nsec),
      .ms        (dl_ms),
      .sum_sec   (dl_sum_sec),
      .sum_nsec  (dl_sum_nsec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ptdm_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      wr_en        = 1'b0;
      wr_entry     = rd_entry;
      later        = (req_ff.now_sec > rd_entry.dl_sec) ||
                     ((req_ff.now_sec == rd_entry.dl_sec) &&
                      (req_ff.now_nsec > rd_entry.dl_nsec));
      case (state_ff)
         ptdm_pkg::S_IDLE: begin
            if (accept) begin
               state_in = ptdm_pkg::S_MUL;
            end
         end
         ptdm_pkg::S_MUL: begin
            state_in = ptdm_pkg::S_ADD;
         end
         ptdm_pkg::S_ADD: begin
            state_in = ptdm_pkg::S_WB;
         end
         ptdm_pkg::S_WB: begin
            state_in           = ptdm_pkg::S_IDLE;
            rsp_valid_in       = 1'b1;
            rsp_in.result_task = tag_ff;
            rsp_in.status      = status_ff;
            if (status_ff == ptdm_pkg::STS_OK) begin
               wr_en = 1'b1;
               case (req_ff.opcode)
                  ptdm_pkg::OP_CREATE: begin
                     wr_entry           = '0;
                     wr_entry.period_ms = req_ff.period_ms;
                     wr_entry.rel_dl_ms = req_ff.deadline_ms;
                     count_in           = count_ff + CNT_W'(1);
                  end
                  ptdm_pkg::OP_CHECK: begin
                     if (later && (rd_entry.miss != ptdm_pkg::MISS_MAX)) begin
                        wr_entry.miss = rd_entry.miss + ptdm_pkg::MISS_W'(1);
                     end
                     rsp_in.missed = later;
                  end
                  default: begin
                     wr_entry.act_sec  = act_sum_sec;
                     wr_entry.act_nsec = act_sum_nsec;
                     wr_entry.dl_sec   = dl_sum_sec;
                     wr_entry.dl_nsec  = dl_sum_nsec;
                  end
               endcase
               if (req_ff.opcode != ptdm_pkg::OP_CREATE) begin
                  rsp_in.miss_total    = wr_entry.miss;
                  rsp_in.next_act_sec  = wr_entry.act_sec;
                  rsp_in.next_act_nsec = wr_entry.act_nsec;
                  rsp_in.abs_dl_sec    = wr_entry.dl_sec;
                  rsp_in.abs_dl_nsec   = wr_entry.dl_nsec;
               end
            end
         end
         default: begin
            state_in = ptdm_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/ptdm_checker.sv -----
module ptdm_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input ptdm_pkg::req_type   req_data,
   input logic                rsp_strobe,
   input ptdm_pkg::rsp_type   rsp_data
);

   // every accepted beat is answered by a result strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_strobe)
      else $error("result strobe missing four cycles after accept");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe without a finished beat");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != ptdm_pkg::STS_OK)) |->
      (!rsp_data.missed && (rsp_data.miss_total == '0) &&
       (rsp_data.next_act_sec == '0) && (rsp_data.abs_dl_sec == '0)))
      else $error("error result carries entry data");

   a_missed_check: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.missed) |-> (rsp_data.miss_total != '0))
      else $error("miss flagged with zero miss count");

endmodule

bind periodic_task_deadline_monitor_unit ptdm_checker u_ptdm_checker (.*);
